>>> src/rtcsnap_pkg.sv
// Shared types and constants for the real-time clock snapshot reader.
`default_nettype none

package rtcsnap_pkg;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_STATUS,
      PH_SECONDS,
      PH_MINUTES,
      PH_HOURS,
      PH_DAY,
      PH_MONTH,
      PH_YEAR,
      PH_CENTURY,
      PH_REGB
   } phase_type;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_DATA  = 1'b1
   } cmd_type;

   typedef enum logic {
      KIND_REQUEST = 1'b0,
      KIND_TIME    = 1'b1
   } kind_type;

   typedef enum logic {
      CSR_CENTURY_REG   = 1'b0,
      CSR_FALLBACK_YEAR = 1'b1
   } csr_index_type;

   localparam logic [6:0] REG_SECONDS = 7'h00;
   localparam logic [6:0] REG_MINUTES = 7'h02;
   localparam logic [6:0] REG_HOURS   = 7'h04;
   localparam logic [6:0] REG_DAY     = 7'h07;
   localparam logic [6:0] REG_MONTH   = 7'h08;
   localparam logic [6:0] REG_YEAR    = 7'h09;
   localparam logic [6:0] REG_STATUSA = 7'h0A;
   localparam logic [6:0] REG_STATUSB = 7'h0B;

   localparam int UIP_BIT       = 7;
   localparam int REGB_BIN_BIT  = 2;
   localparam int REGB_24H_BIT  = 1;

   localparam logic [2:0] FLD_SECONDS = 3'd0;
   localparam logic [2:0] FLD_MINUTES = 3'd1;
   localparam logic [2:0] FLD_HOURS   = 3'd2;
   localparam logic [2:0] FLD_DAY     = 3'd3;
   localparam logic [2:0] FLD_MONTH   = 3'd4;
   localparam logic [2:0] FLD_YEAR    = 3'd5;
   localparam logic [2:0] FLD_CENTURY = 3'd6;
   localparam int         NUM_FIELDS  = 7;

   localparam logic [13:0] FALLBACK_YEAR_RESET = 14'd2021;
   localparam logic [7:0]  FALLBACK_CENT_RESET = 8'd20;
   // Reciprocal of 100 scaled by 2**19; exact for every 14-bit year.
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   typedef struct packed {
      logic [7:0] century;
      logic [7:0] year;
      logic [7:0] month;
      logic [7:0] day;
      logic [7:0] hour;
      logic [7:0] minute;
      logic [7:0] second;
   } raw_fields_type;

   typedef struct packed {
      logic [14:0] full_year;
      logic [7:0]  month;
      logic [7:0]  day;
      logic [7:0]  hour;
      logic [7:0]  minute;
      logic [7:0]  second;
   } time_type;

endpackage

`default_nettype wire

>>> src/rtcsnap_convert.sv
// Converts one stored pass of clock bytes into a binary, 24-hour time with full year.
`default_nettype none

module rtcsnap_convert (
   input  rtcsnap_pkg::raw_fields_type raw,
   input  logic [7:0]                  regb,
   input  logic                        century_en,
   input  logic [7:0]                  fallback_cent,
   input  logic [13:0]                 fallback_year,
   output rtcsnap_pkg::time_type       result
);
   import rtcsnap_pkg::*;

   function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
      logic [7:0] tens;
      tens = {4'd0, v[7:4]};
      return {4'd0, v[3:0]} + (tens << 3) + (tens << 1);
   endfunction

   logic [7:0]  sec_b, min_b, hour_b, day_b, mon_b, year_b, cent_b;
   logic [7:0]  hour_tens, hour_low, hour_24;
   logic [14:0] cent_yr, fb_base, fb_yr, year_full;

   always_comb begin
      hour_tens = {5'd0, raw.hour[6:4]};
      if (regb[REGB_BIN_BIT]) begin
         sec_b  = raw.second;
         min_b  = raw.minute;
         hour_b = raw.hour;
         day_b  = raw.day;
         mon_b  = raw.month;
         year_b = raw.year;
         cent_b = raw.century;
      end else begin
         sec_b  = bcd_to_bin(raw.second);
         min_b  = bcd_to_bin(raw.minute);
         hour_b = ({4'd0, raw.hour[3:0]} + (hour_tens << 3) + (hour_tens << 1))
                  | {raw.hour[7], 7'd0};
         day_b  = bcd_to_bin(raw.day);
         mon_b  = bcd_to_bin(raw.month);
         year_b = bcd_to_bin(raw.year);
         cent_b = bcd_to_bin(raw.century);
      end
   end

   always_comb begin
      hour_low = {1'b0, hour_b[6:0]};
      if (hour_low == 8'd12) begin
         hour_low = 8'd0;
      end
      if (hour_b[7]) begin
         hour_low = hour_low + 8'd12;
      end
      hour_24 = regb[REGB_24H_BIT] ? hour_b : hour_low;
   end

   always_comb begin
      cent_yr = ({7'd0, cent_b} << 6) + ({7'd0, cent_b} << 5) + ({7'd0, cent_b} << 2)
                + {7'd0, year_b};
      fb_base = ({7'd0, fallback_cent} << 6) + ({7'd0, fallback_cent} << 5)
                + ({7'd0, fallback_cent} << 2);
      fb_yr   = fb_base + {7'd0, year_b};
      if (fb_yr < {1'b0, fallback_year}) begin
         fb_yr = fb_yr + 15'd100;
      end
      year_full = century_en ? cent_yr : fb_yr;
   end

   always_comb begin
      result.second    = sec_b;
      result.minute    = min_b;
      result.hour      = hour_24;
      result.day       = day_b;
      result.month     = mon_b;
      result.full_year = year_full;
   end

endmodule

`default_nettype wire

>>> src/rtc_snapshot_reader.sv
// Top level of the real-time clock snapshot reader: read sequencer and result register.
//
//   Group   Direction  Beat carries
//   req_*   in         tuser: cmd; tdata: read_data
//   rsp_*   out        tuser: kind; tdata: reg_index, second, minute, hour, day,
//                      month, full_year
//   csr_*   in         wr_en, addr (register index), wdata
//
// Each request beat is handled in the cycle it is accepted; any response beat it yields
// reaches the result register on the next cycle; one beat per cycle while not stalled.
// Reset is synchronous and returns the sequencer to idle with the result register empty.
// A stalled response holds its beat, and a new request is taken in the same cycle
// the held beat is taken.
`default_nettype none

module rtc_snapshot_reader (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] read_data
   input  logic        req_tuser,  // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // [6:0] reg_index, [14:7] second, [22:15] minute,
                                   // [30:23] hour, [38:31] day, [46:39] month,
                                   // [61:47] full_year, [63:62] zero
   output logic        rsp_tuser,  // [0] kind
   input  logic        csr_wr_en,
   input  logic        csr_addr,
   input  logic [13:0] csr_wdata
);
   import rtcsnap_pkg::*;

   logic [6:0]  century_idx_ff;
   logic [13:0] fallback_year_ff;
   logic [7:0]  fallback_cent_ff;
   logic [26:0] recip_prod;

   phase_type   phase_ff, phase_in;
   logic        first_pass_ff, first_pass_in;
   logic        mismatch_ff, mismatch_in;
   logic [7:0]  field_store_ff [NUM_FIELDS];

   logic        accept;
   logic        is_start;
   logic [7:0]  data;
   logic        store_en;
   logic [2:0]  store_idx;
   logic        mismatch_now;
   logic        pass_again;
   logic        emit;
   kind_type    kind;
   logic [6:0]  req_reg;

   raw_fields_type raw;
   time_type       conv_time;

   logic        rsp_valid_ff;
   logic        rsp_kind_ff;
   logic [63:0] rsp_data_ff;
   logic [63:0] rsp_data_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_start   = (req_tuser == CMD_START);
   assign data       = req_tdata;

   assign recip_prod = {13'd0, csr_wdata} * {14'd0, RECIP_100};

   always_ff @(posedge clock) begin
      if (reset) begin
         century_idx_ff   <= 7'd0;
         fallback_year_ff <= FALLBACK_YEAR_RESET;
         fallback_cent_ff <= FALLBACK_CENT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_CENTURY_REG: begin
               century_idx_ff <= csr_wdata[6:0];
            end
            CSR_FALLBACK_YEAR: begin
               fallback_year_ff <= csr_wdata;
               fallback_cent_ff <= recip_prod[RECIP_SHIFT +: 8];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      store_en  = 1'b0;
      store_idx = FLD_SECONDS;
      unique case (phase_ff)
         PH_SECONDS: begin store_en = 1'b1; store_idx = FLD_SECONDS; end
         PH_MINUTES: begin store_en = 1'b1; store_idx = FLD_MINUTES; end
         PH_HOURS:   begin store_en = 1'b1; store_idx = FLD_HOURS;   end
         PH_DAY:     begin store_en = 1'b1; store_idx = FLD_DAY;     end
         PH_MONTH:   begin store_en = 1'b1; store_idx = FLD_MONTH;   end
         PH_YEAR:    begin store_en = 1'b1; store_idx = FLD_YEAR;    end
         PH_CENTURY: begin store_en = 1'b1; store_idx = FLD_CENTURY; end
         default: begin
         end
      endcase
      mismatch_now = mismatch_ff
                     || (store_en && !first_pass_ff && field_store_ff[store_idx] != data);
      pass_again   = first_pass_ff || mismatch_now;
   end

   // Next state of the sequencer.
   always_comb begin
      phase_in      = phase_ff;
      first_pass_in = first_pass_ff;
      mismatch_in   = mismatch_ff;
      if (is_start) begin
         phase_in      = PH_STATUS;
         first_pass_in = 1'b1;
         mismatch_in   = 1'b0;
      end else begin
         unique case (phase_ff) inside
            PH_STATUS: begin
               if (!data[UIP_BIT]) begin
                  phase_in = PH_SECONDS;
               end
            end
            PH_SECONDS: begin phase_in = PH_MINUTES; mismatch_in = mismatch_now; end
            PH_MINUTES: begin phase_in = PH_HOURS;   mismatch_in = mismatch_now; end
            PH_HOURS:   begin phase_in = PH_DAY;     mismatch_in = mismatch_now; end
            PH_DAY:     begin phase_in = PH_MONTH;   mismatch_in = mismatch_now; end
            PH_MONTH:   begin phase_in = PH_YEAR;    mismatch_in = mismatch_now; end
            PH_YEAR, PH_CENTURY: begin
               if (phase_ff == PH_YEAR && century_idx_ff != 7'd0) begin
                  phase_in    = PH_CENTURY;
                  mismatch_in = mismatch_now;
               end else if (pass_again) begin
                  phase_in      = PH_STATUS;
                  first_pass_in = 1'b0;
                  mismatch_in   = 1'b0;
               end else begin
                  phase_in    = PH_REGB;
                  mismatch_in = mismatch_now;
               end
            end
            PH_REGB: begin
               phase_in      = PH_IDLE;
               first_pass_in = 1'b1;
               mismatch_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // Response produced by the accepted beat.
   always_comb begin
      emit    = 1'b1;
      kind    = KIND_REQUEST;
      req_reg = REG_STATUSA;
      if (!is_start) begin
         unique case (phase_ff) inside
            PH_IDLE:    emit = 1'b0;
            PH_STATUS:  req_reg = data[UIP_BIT] ? REG_STATUSA : REG_SECONDS;
            PH_SECONDS: req_reg = REG_MINUTES;
            PH_MINUTES: req_reg = REG_HOURS;
            PH_HOURS:   req_reg = REG_DAY;
            PH_DAY:     req_reg = REG_MONTH;
            PH_MONTH:   req_reg = REG_YEAR;
            PH_YEAR, PH_CENTURY: begin
               if (phase_ff == PH_YEAR && century_idx_ff != 7'd0) begin
                  req_reg = century_idx_ff;
               end else begin
                  req_reg = pass_again ? REG_STATUSA : REG_STATUSB;
               end
            end
            PH_REGB: kind = KIND_TIME;
            default: emit = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         first_pass_ff <= 1'b1;
         mismatch_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         first_pass_ff <= first_pass_in;
         mismatch_ff   <= mismatch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !is_start && store_en) begin
         field_store_ff[store_idx] <= data;
      end
   end

   always_comb begin
      raw.second  = field_store_ff[FLD_SECONDS];
      raw.minute  = field_store_ff[FLD_MINUTES];
      raw.hour    = field_store_ff[FLD_HOURS];
      raw.day     = field_store_ff[FLD_DAY];
      raw.month   = field_store_ff[FLD_MONTH];
      raw.year    = field_store_ff[FLD_YEAR];
      raw.century = field_store_ff[FLD_CENTURY];
   end

   rtcsnap_convert u_convert (
      .raw           (raw),
      .regb          (data),
      .century_en    (century_idx_ff != 7'd0),
      .fallback_cent (fallback_cent_ff),
      .fallback_year (fallback_year_ff),
      .result        (conv_time)
   );

   always_comb begin
      if (kind == KIND_TIME) begin
         rsp_data_in = {2'b00, conv_time.full_year, conv_time.month, conv_time.day,
                        conv_time.hour, conv_time.minute, conv_time.second, 7'd0};
      end else begin
         rsp_data_in = {57'd0, req_reg};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_kind_ff <= kind;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> src/rtcsnap_checker.sv
// Port-level checks for the real-time clock snapshot reader, bound to its top level.
`default_nettype none

module rtcsnap_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);
   import rtcsnap_pkg::*;

   // A held response beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   // An empty result register never back-pressures the request side.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty result register");

   // An accepted start beat yields a status register A read request next cycle.
   a_start_request: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_START |=>
         rsp_tvalid && rsp_tuser == KIND_REQUEST && rsp_tdata[6:0] == REG_STATUSA)
      else $error("start beat did not produce a status read request");

   // Fields that do not belong to the beat's kind are zero.
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == KIND_REQUEST && rsp_tdata[63:7] == 57'd0)
                  || (rsp_tuser == KIND_TIME && rsp_tdata[6:0] == 7'd0
                      && rsp_tdata[63:62] == 2'd0))
      else $error("response carries bits outside its kind");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind rtc_snapshot_reader rtcsnap_checker u_rtcsnap_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
